[rtl/tsas_pkg.sv]
// Shared constants for the time-slot average store: field widths, action codes,
// register indexes and default parameter values. No dependencies.
`default_nettype none
package tsas_pkg;
    localparam int TSAS_MAX_SLOTS     = 128;
    localparam int TSAS_FRACTION_BITS = 8;

    localparam int ACT_W  = 2;
    localparam int TIME_W = 21;
    localparam int SMP_W  = 16;
    localparam int RD_W   = 24;
    localparam int MPS_W  = 11;
    localparam int CNT_W  = 8;
    localparam int INE_W  = 8;
    localparam int DEF_W  = 16;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [ACT_W-1:0] ACT_STORE     = 2'd0;
    localparam logic [ACT_W-1:0] ACT_OVERWRITE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_READ      = 2'd2;
    localparam logic [ACT_W-1:0] ACT_REFILL    = 2'd3;

    localparam logic [1:0] REG_MPS     = 2'd0;
    localparam logic [1:0] REG_COUNT   = 2'd1;
    localparam logic [1:0] REG_INERTIA = 2'd2;
    localparam logic [1:0] REG_DEFAULT = 2'd3;

    localparam logic [MPS_W-1:0] MPS_RESET     = 11'd15;
    localparam logic [CNT_W-1:0] COUNT_RESET   = 8'd96;
    localparam logic [INE_W-1:0] INERTIA_RESET = 8'd8;
    localparam logic [DEF_W-1:0] DEFAULT_RESET = 16'd0;
endpackage
`default_nettype wire

[rtl/tsas_if.sv]
// Request and result channel interfaces for the time-slot average store.
// Depends on tsas_pkg for field widths.
`default_nettype none
interface tsas_in_if import tsas_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [ACT_W-1:0]         action;
    logic signed [TIME_W-1:0] time_minutes;
    logic signed [SMP_W-1:0]  sample_value;
    modport source (output valid, action, time_minutes, sample_value, input ready);
    modport sink   (input valid, action, time_minutes, sample_value, output ready);
endinterface

interface tsas_out_if import tsas_pkg::*; #(parameter int SW = 7) ();
    logic                   valid;
    logic                   ready;
    logic [SW-1:0]          slot_index;
    logic signed [RD_W-1:0] read_value;
    logic                   accepted;
    logic                   committed;
    logic [SW-1:0]          committed_slot;
    logic                   period_wrapped;
    modport source (output valid, slot_index, read_value, accepted, committed,
                    committed_slot, period_wrapped, input ready);
    modport sink   (input valid, slot_index, read_value, accepted, committed,
                    committed_slot, period_wrapped, output ready);
endinterface
`default_nettype wire

[rtl/tsas_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module tsas_ram #(
    parameter int W = 32,
    parameter int D = 128,
    localparam int AW = (D > 1) ? $clog2(D) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [W-1:0]  i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic [W-1:0]       o_rdata
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[rtl/tsas_div.sv]
// Unsigned restoring divider, one quotient bit per cycle.
// No dependencies.
`default_nettype none
module tsas_div #(
    parameter int NW  = 32,
    parameter int DVW = 11
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [NW-1:0]  i_dividend,
    input  wire logic [DVW-1:0] i_divisor,
    output logic                o_done,
    output logic [NW-1:0]       o_quot,
    output logic [DVW-1:0]      o_rem
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0]  r_dd;
    logic [DVW-1:0] r_rem;
    logic [DVW-1:0] r_dv;
    logic [CW-1:0]  r_cnt;
    logic           r_done;
    logic [DVW:0]   rem_sh;
    logic           ge;
    logic [DVW:0]   rem_sub;

    assign rem_sh  = {r_rem, r_dd[NW-1]};
    assign ge      = rem_sh >= {1'b0, r_dv};
    assign rem_sub = rem_sh - {1'b0, r_dv};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= CW'(NW);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - 1'b1;
            r_done <= (r_cnt == CW'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dd  <= i_dividend;
            r_dv  <= i_divisor;
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            r_dd  <= {r_dd[NW-2:0], ge};
            r_rem <= ge ? rem_sub[DVW-1:0] : rem_sh[DVW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_dd;
    assign o_rem  = r_rem;
endmodule
`default_nettype wire

[rtl/time_slot_average_store_unit.sv]
// Time-slot average store: one running average per slot of a repeating period.
// Every request maps time to a slot and wraps it on the bit-serial divider; a fold or
// a read then also divides the accumulator there. A finished result waits while the
// result register is full; one request is taken at a time, the next one once the
// result registers.
// Reset (synchronous, active low) restores the registers and marks every slot as
// holding the fill value at once through per-slot valid bits; refill does the same.
`default_nettype none
module time_slot_average_store_unit import tsas_pkg::*; #(
    parameter int MAX_SLOTS     = TSAS_MAX_SLOTS,
    parameter int FRACTION_BITS = TSAS_FRACTION_BITS,
    localparam int SW = $clog2(MAX_SLOTS)
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    tsas_in_if.sink                  i_req,
    tsas_out_if.source               o_rsp,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [PADDR_W-1:0]  paddr,
    input  wire logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]       prdata,
    output logic                     pready
);
    // Accumulator: sample bits + inertia bits + fraction bits.
    localparam int ACC_W = SMP_W + INE_W + FRACTION_BITS;
    localparam int CW    = $clog2(MAX_SLOTS + 1);
    localparam int DVW   = (CW > MPS_W) ? CW : MPS_W;
    localparam int XW    = CW + 2;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MAP  = 3'd1;
    localparam logic [2:0] S_WRAP = 3'd2;
    localparam logic [2:0] S_DEC  = 3'd3;
    localparam logic [2:0] S_RAM  = 3'd4;
    localparam logic [2:0] S_AVG  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    // Configuration registers.
    logic [MPS_W-1:0] r_mps;
    logic [CNT_W-1:0] r_cnt;
    logic [INE_W-1:0] r_ine;
    logic [DEF_W-1:0] r_def;

    logic [2:0]              r_state, n_state;
    logic [ACT_W-1:0]        r_act;
    logic                    r_tneg;
    logic [SMP_W-1:0]        r_sample;
    logic [SW-1:0]           r_slot;
    logic [SW-1:0]           r_last;
    logic                    r_last_vld;
    logic [SMP_W-1:0]        r_held;
    logic [ACC_W-1:0]        r_fill;
    logic [MAX_SLOTS-1:0]    r_ent_vld;
    logic                    r_rd_vld;
    logic [ACC_W-1:0]        r_acc;
    logic                    r_fold;

    logic [RD_W-1:0] r_res_read;
    logic            r_res_acc, r_res_com, r_res_wrap;
    logic [SW-1:0]   r_res_cslot;

    logic            r_ov;
    logic [SW-1:0]   r_o_slot, r_o_cslot;
    logic [RD_W-1:0] r_o_read;
    logic            r_o_acc, r_o_com, r_o_wrap;

    // Effective configuration: zero reads as one, slot count saturates.
    logic [MPS_W-1:0] mps_e;
    logic [CW-1:0]    cnt_e;
    logic [INE_W-1:0] ine_e;

    assign mps_e = (r_mps == '0) ? MPS_W'(1) : r_mps;
    assign ine_e = (r_ine == '0) ? INE_W'(1) : r_ine;
    always_comb begin
        if (r_cnt == '0) begin
            cnt_e = CW'(1);
        end else if (32'(r_cnt) > 32'(MAX_SLOTS)) begin
            cnt_e = CW'(MAX_SLOTS);
        end else begin
            cnt_e = CW'(r_cnt);
        end
    end

    // APB register port.
    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mps <= MPS_RESET;
            r_cnt <= COUNT_RESET;
            r_ine <= INERTIA_RESET;
            r_def <= DEFAULT_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_MPS:     r_mps <= pwdata[MPS_W-1:0];
                REG_COUNT:   r_cnt <= pwdata[CNT_W-1:0];
                REG_INERTIA: r_ine <= pwdata[INE_W-1:0];
                REG_DEFAULT: r_def <= pwdata[DEF_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_MPS:     prdata = PDATA_W'(r_mps);
            REG_COUNT:   prdata = PDATA_W'(r_cnt);
            REG_INERTIA: prdata = PDATA_W'(r_ine);
            REG_DEFAULT: prdata = PDATA_W'($signed(r_def));
            default:     prdata = '0;
        endcase
    end

    // Shared divider: time/minutes, quotient mod count, accumulator/inertia.
    logic             div_start, div_done;
    logic [ACC_W-1:0] div_dd, div_quot;
    logic [DVW-1:0]   div_dv, div_rem;

    logic             in_acc;
    logic [ACC_W-1:0] t_ext, t_mag;
    logic [ACC_W-1:0] acc_now, acc_mag;

    assign in_acc  = i_req.valid && i_req.ready;
    assign t_ext   = ACC_W'($signed(i_req.time_minutes));
    assign t_mag   = i_req.time_minutes[TIME_W-1] ? (~t_ext + 1'b1) : t_ext;

    always_comb begin
        div_start = 1'b0;
        div_dd    = t_mag;
        div_dv    = DVW'(mps_e);
        unique case (r_state)
            S_IDLE: div_start = in_acc;
            S_MAP: begin
                div_start = div_done;
                div_dd    = div_quot;
                div_dv    = DVW'(cnt_e);
            end
            S_RAM: begin
                div_start = 1'b1;
                div_dd    = acc_mag;
                div_dv    = DVW'(ine_e);
            end
            default: ;
        endcase
    end

    tsas_div #(.NW(ACC_W), .DVW(DVW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dd),
        .i_divisor  (div_dv),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // Slot table memory.
    logic             ram_we;
    logic [SW-1:0]    ram_waddr, ram_raddr;
    logic [ACC_W-1:0] ram_wdata, ram_rdata;

    tsas_ram #(.W(ACC_W), .D(MAX_SLOTS)) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign acc_now = r_rd_vld ? ram_rdata : r_fill;
    assign acc_mag = acc_now[ACC_W-1] ? (~acc_now + 1'b1) : acc_now;

    // Slot from the wrap remainder: negative time counts back from the end.
    logic [CW-1:0] wrap_r;
    logic [SW-1:0] slot_new;
    assign wrap_r   = div_rem[CW-1:0];
    assign slot_new = (r_tneg && wrap_r != '0) ? SW'(cnt_e - wrap_r) : SW'(wrap_r);

    // Store window decision on the slot relative to the last one.
    logic signed [XW-1:0] rel, prev, diff, half;
    logic st_ok, st_adv, st_fold;
    always_comb begin
        prev = XW'(r_last);
        rel  = XW'(r_slot);
        if (r_last_vld && r_last > r_slot) begin
            rel = rel + XW'(cnt_e);
        end
        diff    = rel - prev;
        half    = XW'(cnt_e >> 1);
        st_ok   = !r_last_vld || (diff < half);
        st_adv  = r_last_vld && (rel > prev);
        st_fold = st_adv && (XW'(r_last) < XW'(cnt_e));
    end

    // Averaging arithmetic.
    logic signed [ACC_W-1:0] q_s, fold_val, smp_scaled, held_scaled;
    logic [RD_W-1:0]         rd_sat;
    assign q_s         = r_acc[ACC_W-1] ? $signed(~div_quot + 1'b1) : $signed(div_quot);
    assign smp_scaled  = $signed(ACC_W'($signed(r_sample))) <<< FRACTION_BITS;
    assign held_scaled = $signed(ACC_W'($signed(r_held))) <<< FRACTION_BITS;
    assign fold_val    = $signed(r_acc) - q_s + held_scaled;

    always_comb begin
        if (q_s > $signed(ACC_W'({1'b0, {(RD_W-1){1'b1}}}))) begin
            rd_sat = {1'b0, {(RD_W-1){1'b1}}};
        end else if (q_s < $signed(ACC_W'($signed({1'b1, {(RD_W-1){1'b0}}})))) begin
            rd_sat = {1'b1, {(RD_W-1){1'b0}}};
        end else begin
            rd_sat = q_s[RD_W-1:0];
        end
    end

    // Memory port control: overwrite writes in decode, fold writes after the divide.
    always_comb begin
        ram_raddr = (r_act == ACT_STORE) ? r_last : r_slot;
        ram_we    = 1'b0;
        ram_waddr = r_slot;
        ram_wdata = smp_scaled;
        if (r_state == S_DEC && r_act == ACT_OVERWRITE) begin
            ram_we = 1'b1;
        end else if (r_state == S_AVG && div_done && r_fold) begin
            ram_we    = 1'b1;
            ram_waddr = r_last;
            ram_wdata = fold_val;
        end
    end

    // Sequencer.
    logic out_free;
    assign out_free = !r_ov || o_rsp.ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_acc) n_state = S_MAP;
            S_MAP:  if (div_done) n_state = S_WRAP;
            S_WRAP: if (div_done) n_state = S_DEC;
            S_DEC: begin
                if (r_act == ACT_READ || (r_act == ACT_STORE && st_ok && st_fold)) begin
                    n_state = S_RAM;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_RAM:  n_state = S_AVG;
            S_AVG:  if (div_done) n_state = S_FIN;
            S_FIN:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control state: last slot tracking, valid bits, fill value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last     <= '0;
            r_last_vld <= 1'b0;
            r_ent_vld  <= '0;
            r_fill     <= '0;
        end else begin
            if (r_state == S_DEC) begin
                case (r_act)
                    ACT_STORE: begin
                        if (st_ok && !st_fold && (!r_last_vld || st_adv)) begin
                            r_last     <= r_slot;
                            r_last_vld <= 1'b1;
                        end
                    end
                    ACT_OVERWRITE: r_ent_vld[r_slot] <= 1'b1;
                    ACT_REFILL: begin
                        r_ent_vld <= '0;
                        r_fill    <= (ACC_W'($signed(r_def)) * ACC_W'({1'b0, ine_e}))
                                     <<< FRACTION_BITS;
                    end
                    default: ;
                endcase
            end
            if (r_state == S_AVG && div_done && r_fold) begin
                r_ent_vld[r_last] <= 1'b1;
                r_last            <= r_slot;
            end
        end
    end

    // Request capture and per-request results.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && in_acc) begin
            r_act    <= i_req.action;
            r_tneg   <= i_req.time_minutes[TIME_W-1];
            r_sample <= i_req.sample_value;
        end
        if (r_state == S_WRAP && div_done) begin
            r_slot <= slot_new;
        end
        if (r_state == S_DEC) begin
            r_rd_vld    <= r_ent_vld[ram_raddr];
            r_fold      <= (r_act == ACT_STORE) && st_ok && st_fold;
            r_res_read  <= '0;
            r_res_acc   <= (r_act == ACT_STORE) && st_ok;
            r_res_com   <= 1'b0;
            r_res_cslot <= '0;
            r_res_wrap  <= 1'b0;
            if (r_act == ACT_STORE && st_ok && !st_fold) begin
                r_held <= r_sample;
            end
        end
        if (r_state == S_RAM) begin
            r_acc <= acc_now;
        end
        if (r_state == S_AVG && div_done) begin
            if (r_fold) begin
                r_res_com   <= 1'b1;
                r_res_cslot <= r_last;
                r_res_wrap  <= r_last > r_slot;
                r_held      <= r_sample;
            end else begin
                r_res_read <= rd_sat;
            end
        end
    end

    // Output register: holds one result while the next request runs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (r_state == S_FIN && out_free) begin
            r_ov <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN && out_free) begin
            r_o_slot  <= r_slot;
            r_o_read  <= r_res_read;
            r_o_acc   <= r_res_acc;
            r_o_com   <= r_res_com;
            r_o_cslot <= r_res_cslot;
            r_o_wrap  <= r_res_wrap;
        end
    end

    assign i_req.ready          = (r_state == S_IDLE);
    assign o_rsp.valid          = r_ov;
    assign o_rsp.slot_index     = r_o_slot;
    assign o_rsp.read_value     = r_o_read;
    assign o_rsp.accepted       = r_o_acc;
    assign o_rsp.committed      = r_o_com;
    assign o_rsp.committed_slot = r_o_cslot;
    assign o_rsp.period_wrapped = r_o_wrap;

`ifndef SYNTH
    a_last_vld_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_last_vld |=> r_last_vld)
        else $error("last slot valid dropped");

    a_commit_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.committed |-> o_rsp.accepted)
        else $error("commit without accepted store");

    a_ram_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_DEC || r_state == S_AVG))
        else $error("table write outside decode or average");

    a_fold_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_AVG && r_fold) |-> (XW'(r_last) < XW'(cnt_e)))
        else $error("fold into slot beyond count");
`endif
endmodule
`default_nettype wire

[sim/tb_top.sv]
// Self-checking testbench for time_slot_average_store_unit.
// Depends on tsas_pkg and the tsas_in_if / tsas_out_if interfaces; drives requests,
// programs registers over APB while idle, and checks every result against a predictor or a typed-in expectation.
module tb_top;
    import tsas_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [ACT_W-1:0] action;
        int               tmin;
        int               smp;
    } req_t;

    typedef struct {
        logic [6:0]  slot;
        logic [23:0] rdv;
        logic        acc;
        logic        com;
        logic [6:0]  cslot;
        logic        wrap;
    } res_t;

    // Directed table row: request plus an optional typed-in expectation.
    typedef struct {
        logic [ACT_W-1:0] action;
        int               tmin;
        int               smp;
        bit               fixed;
        res_t             want;
    } row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    tsas_in_if  req_if ();
    tsas_out_if #(.SW(7)) rsp_if ();

    time_slot_average_store_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_if.sink), .o_rsp(rsp_if.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Shadow registers and slot table of the predictor.
    int     mps_reg, count_reg, inertia_reg, dflt_reg;
    longint slot_acc [128];
    int     prev_slot;
    bit     prev_valid;
    longint held;

    res_t   expected_q [$];
    int     errors = 0;
    int     idle_cycles = 0;
    bit     rx_hold = 1'b0;
    bit     quiet = 1'b0;
    bit     stim_done = 1'b0;

    function automatic int eff_count();
        if (count_reg == 0) return 1;
        if (count_reg > 128) return 128;
        return count_reg;
    endfunction

    function automatic void fill_table();
        longint v;
        v = longint'(dflt_reg) * (inertia_reg == 0 ? 1 : inertia_reg) * 256;
        foreach (slot_acc[i]) slot_acc[i] = v;
    endfunction

    function automatic int slot_of(int t);
        int n, s;
        n = eff_count();
        s = t / (mps_reg == 0 ? 1 : mps_reg);   // SV divide truncates toward zero
        s = s % n;
        if (s < 0) s += n;
        return s;
    endfunction

    // Compute the result of one request and advance the shadow state.
    function automatic res_t predict_slot_update(req_t r);
        res_t   o;
        int     n, s, rel;
        longint a, q, ine;
        n   = eff_count();
        s   = slot_of(r.tmin);
        ine = (inertia_reg == 0) ? 1 : inertia_reg;
        o   = '{slot: s[6:0], rdv: '0, acc: 0, com: 0, cslot: '0, wrap: 0};
        case (r.action)
            ACT_STORE: begin
                rel = s;
                if (prev_valid && prev_slot > rel) rel += n;
                if (!prev_valid || (rel - prev_slot) < n / 2) begin
                    o.acc = 1;
                    if (prev_valid && rel > prev_slot) begin
                        if (prev_slot < n) begin
                            a = slot_acc[prev_slot];
                            slot_acc[prev_slot] = a - a / ine + held * 256;
                            o.com   = 1;
                            o.cslot = prev_slot[6:0];
                            o.wrap  = prev_slot > s;
                        end
                        prev_slot = s;
                    end else if (!prev_valid) begin
                        prev_slot  = s;
                        prev_valid = 1;
                    end
                    held = r.smp;
                end
            end
            ACT_OVERWRITE: slot_acc[s] = longint'(r.smp) * 256;
            ACT_READ: begin
                q = slot_acc[s] / ine;
                if (q > 8388607) q = 8388607;
                if (q < -8388608) q = -8388608;
                o.rdv = q[23:0];
            end
            default: fill_table();
        endcase
        return o;
    endfunction

    function automatic void reset_model();
        mps_reg = 15; count_reg = 96; inertia_reg = 8; dflt_reg = 0;
        fill_table();
        prev_slot = 0; prev_valid = 0; held = 0;
    endfunction

    // APB write: setup cycle, then access cycle; register latches at the access edge.
    task automatic write_reg(logic [1:0] idx, int val);
        @(posedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= PADDR_W'({idx, 2'b00}); pwdata <= PDATA_W'(val);
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (idx)
            REG_MPS:     mps_reg = val & 32'h7FF;
            REG_COUNT:   count_reg = val & 32'hFF;
            REG_INERTIA: inertia_reg = val & 32'hFF;
            default:     dflt_reg = int'(signed'(16'(val)));
        endcase
    endtask

    task automatic set_config(int m, int c, int ine, int d);
        write_reg(REG_MPS, m);
        write_reg(REG_COUNT, c);
        write_reg(REG_INERTIA, ine);
        write_reg(REG_DEFAULT, d);
    endtask

    // Drop the request line, wait for every outstanding result, then for the
    // block's longest latency.
    task automatic drain();
        req_if.valid <= 0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    // Offer one request, with an optional random gap, and hold it until accepted.
    task automatic send(req_t r, res_t fixed_want, bit use_fixed);
        res_t p;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            req_if.valid <= 0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        req_if.valid        <= 1;
        req_if.action       <= r.action;
        req_if.time_minutes <= TIME_W'(r.tmin);
        req_if.sample_value <= SMP_W'(r.smp);
        do @(posedge i_clk); while (!req_if.ready);
        p = predict_slot_update(r);
        expected_q.insert(expected_q.size(), use_fixed ? fixed_want : p);
    endtask

    task automatic send_random(int count, int span);
        req_t r;
        res_t none;
        int   base;
        none = '{default: '0};
        base = $urandom_range(0, 4000) - 2000;
        repeat (count) begin
            // Mostly stores marching forward in time, so folds happen often.
            case ($urandom_range(0, 9))
                0: r.action = ACT_OVERWRITE;
                1, 2: r.action = ACT_READ;
                3: r.action = ($urandom_range(0, 7) == 0) ? ACT_REFILL : ACT_STORE;
                default: r.action = ACT_STORE;
            endcase
            if ($urandom_range(0, 9) == 0)
                r.tmin = int'(signed'(21'($urandom())));
            else begin
                base += $urandom_range(0, span);
                r.tmin = base;
            end
            r.smp = int'(signed'(16'($urandom())));
            send(r, none, 0);
        end
    endtask

    // Result side: random stalls, one long hold-off, field-by-field compare.
    initial begin
        rsp_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold) rsp_if.ready <= 0;
            else if (!quiet && $urandom_range(0, 5) == 0) begin
                rsp_if.ready <= 0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
                rsp_if.ready <= 1;
            end else rsp_if.ready <= 1;
        end
    end

    always @(posedge i_clk) begin
        res_t e;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result slot=%0d", rsp_if.slot_index);
            end else begin
                e = expected_q.pop_front();
                if (rsp_if.slot_index !== e.slot || rsp_if.read_value !== e.rdv ||
                    rsp_if.accepted !== e.acc || rsp_if.committed !== e.com ||
                    rsp_if.committed_slot !== e.cslot || rsp_if.period_wrapped !== e.wrap) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch exp slot=%0d rd=%h acc=%b com=%b cs=%0d wr=%b / got slot=%0d rd=%h acc=%b com=%b cs=%0d wr=%b",
                            e.slot, e.rdv, e.acc, e.com, e.cslot, e.wrap,
                            rsp_if.slot_index, rsp_if.read_value, rsp_if.accepted,
                            rsp_if.committed, rsp_if.committed_slot, rsp_if.period_wrapped);
                end
            end
        end
    end

    // Watchdog: count cycles without any accepted request or result or APB select.
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || psel)
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // Directed table: reset defaults (15 min, 96 slots, inertia 8, default 0).
    row_t dir_rows [] = '{
        '{ACT_READ,      0,        0,      1, '{0, 0, 0, 0, 0, 0}},
        '{ACT_READ,      1439,     0,      1, '{95, 0, 0, 0, 0, 0}},
        '{ACT_READ,      -1,       0,      1, '{0, 0, 0, 0, 0, 0}},
        '{ACT_READ,      -16,      0,      1, '{95, 0, 0, 0, 0, 0}},
        '{ACT_STORE,     30,       100,    1, '{2, 0, 1, 0, 0, 0}},
        '{ACT_STORE,     40,       200,    1, '{2, 0, 1, 0, 0, 0}},
        '{ACT_STORE,     45,       -5,     1, '{3, 0, 1, 1, 2, 0}},
        '{ACT_STORE,     1000,     7,      1, '{66, 0, 0, 0, 0, 0}},
        '{ACT_READ,      30,       0,      0, '{default: '0}},
        '{ACT_OVERWRITE, 60,       32767,  0, '{default: '0}},
        '{ACT_READ,      60,       0,      0, '{default: '0}},
        '{ACT_OVERWRITE, 75,       -32768, 0, '{default: '0}},
        '{ACT_READ,      75,       0,      0, '{default: '0}},
        '{ACT_STORE,     1425,     1,      0, '{default: '0}},
        '{ACT_STORE,     1440,     2,      0, '{default: '0}},
        '{ACT_STORE,     1048575,  32767,  0, '{default: '0}},
        '{ACT_STORE,     -1048576, -32768, 0, '{default: '0}},
        '{ACT_REFILL,    0,        0,      0, '{default: '0}},
        '{ACT_READ,      60,       0,      0, '{default: '0}}
    };

    initial begin
        req_t r;
        req_if.valid = 0; req_if.action = ACT_STORE;
        req_if.time_minutes = '0; req_if.sample_value = '0;
        reset_model();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            r = '{dir_rows[i].action, dir_rows[i].tmin, dir_rows[i].smp};
            send(r, dir_rows[i].want, dir_rows[i].fixed);
        end
        drain();

        // Extremes: smallest slots, largest default and inertia, then inertia one,
        // so the read saturates at the top of the range.
        set_config(1, 2, 255, 32767);
        r = '{ACT_REFILL, 0, 0};
        send(r, '{default: '0}, 0);
        drain();
        write_reg(REG_INERTIA, 1);
        r = '{ACT_READ, 1, 0};
        send(r, '{7'd1, 24'h7FFFFF, 1'b0, 1'b0, 7'd0, 1'b0}, 1);
        send_random(150, 2);
        drain();

        // Shrink the period below the last slot to make it stale.
        set_config(1440, 128, 255, -32768);
        send_random(150, 3000);
        drain();
        write_reg(REG_COUNT, 4);
        send_random(100, 3);
        drain();

        // Zero registers are treated as one; long output hold-off fills the block.
        set_config(0, 0, 0, 1234);
        fork
            send_random(50, 5);
            begin
                rx_hold = 1;
                repeat (400) @(posedge i_clk);
                rx_hold = 0;
            end
        join
        drain();

        set_config(7, 200, 3, -77);
        send_random(300, 10);
        drain();

        set_config(15, 96, 8, 0);
        send_random(600, 20);
        drain();

        set_config($urandom_range(1, 60), $urandom_range(2, 128), $urandom_range(1, 255),
                   int'(signed'(16'($urandom()))));
        send_random(300, 40);
        quiet = 1;
        send_random(250, 15);
        stim_done = 1;

        drain();
        if (errors == 0 && expected_q.size() == 0) $display("tb_top: done, clean");
        else $display("tb_top: done, errors");
        $finish;
    end
endmodule

[filelist.f]
rtl/tsas_pkg.sv
rtl/tsas_if.sv
rtl/tsas_ram.sv
rtl/tsas_div.sv
rtl/time_slot_average_store_unit.sv
sim/tb_top.sv
